FILE: src/nhq_pkg.sv
// shared types, constants and helpers for the nvme host queue pair engine
package nhq_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int NUM_QUEUES  = 2;

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int QIDX_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

    localparam logic [19:0] DOORBELL_BASE = 20'h01000;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 96;
    localparam int M_TUSER_W = 4;

    typedef enum logic {
        OP_SUBMIT   = 1'b0,
        OP_COMPLETE = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        KIND_SUBMITTED   = 3'd0,
        KIND_NOT_YET     = 3'd1,
        KIND_ID_MISMATCH = 3'd2,
        KIND_DONE_OK     = 3'd3,
        KIND_DONE_ERROR  = 3'd4
    } kind_t;

    typedef struct packed {
        op_t         op;
        logic        queue_id;
        logic [15:0] command_low_word;
        logic [15:0] completion_status;
        logic [15:0] completion_id;
    } nhq_in_t;

    typedef struct packed {
        kind_t       result_kind;
        logic [5:0]  slot_index;
        logic [31:0] command_word_zero;
        logic [15:0] command_tag;
        logic        doorbell_write;
        logic [19:0] doorbell_offset;
        logic [5:0]  doorbell_value;
        logic [14:0] status_code;
    } nhq_out_t;

    // queue number folded into the populated range
    function automatic logic [QIDX_W-1:0] queue_sel(input logic qid);
        logic [QIDX_W:0] ext;
        ext = {{QIDX_W{1'b0}}, qid};
        if (ext >= (QIDX_W + 1)'(NUM_QUEUES)) begin
            ext = ext - (QIDX_W + 1)'(NUM_QUEUES);
        end
        return ext[QIDX_W-1:0];
    endfunction

    // pointer reported in six bits whatever the depth
    function automatic logic [5:0] ptr_out(input logic [PTR_W-1:0] p);
        logic [PTR_W+5:0] ext;
        ext = {6'b0, p};
        return ext[5:0];
    endfunction

endpackage

FILE: src/nhq_in_stage.sv
// input register of the queue pair engine, holds one accepted transaction
module nhq_in_stage
    import nhq_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [S_TUSER_W-1:0] s_tuser,
    input  logic                 advance,
    output logic                 item_valid,
    output nhq_in_t              item
);

    logic    valid_reg;
    logic    valid_next;
    nhq_in_t item_reg;

    assign s_tready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (advance) begin
            valid_next = 1'b0;
        end
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.op                <= op_t'(s_tuser[0]);
            item_reg.queue_id          <= s_tuser[1];
            item_reg.command_low_word  <= s_tdata[15:0];
            item_reg.completion_status <= s_tdata[31:16];
            item_reg.completion_id     <= s_tdata[47:32];
        end
    end

endmodule

FILE: src/nhq_engine.sv
// per-queue pointers, phase and tag state with the submit and completion logic
module nhq_engine
    import nhq_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       advance,
    input  nhq_in_t    item,
    input  logic [3:0] stride_exp,
    output nhq_out_t   result
);

    logic [PTR_W-1:0] tail_reg  [NUM_QUEUES];
    logic [PTR_W-1:0] head_reg  [NUM_QUEUES];
    logic             phase_reg [NUM_QUEUES];
    logic [15:0]      tag_reg   [NUM_QUEUES];

    logic [PTR_W-1:0] tail_next;
    logic [PTR_W-1:0] head_next;
    logic             phase_next;
    logic [15:0]      tag_next;
    logic             wr_tail;
    logic             wr_head;

    logic [QIDX_W-1:0] q;
    logic [PTR_W-1:0]  tail;
    logic [PTR_W-1:0]  head;
    logic              phase;
    logic [15:0]       last_tag;
    logic [15:0]       tag_inc;
    logic [19:0]       bell_idx;
    logic [19:0]       bell_off;

    assign q        = queue_sel(item.queue_id);
    assign tail     = tail_reg[q];
    assign head     = head_reg[q];
    assign phase    = phase_reg[q];
    assign last_tag = tag_reg[q];
    assign tag_inc  = last_tag + 16'd1;

    // doorbell index is 2*queue plus one for the completion side
    assign bell_idx = 20'({q, item.op == OP_COMPLETE});
    assign bell_off = (bell_idx << ({1'b0, stride_exp} + 5'd2)) + DOORBELL_BASE;

    always_comb begin
        tail_next  = tail;
        head_next  = head;
        phase_next = phase;
        tag_next   = last_tag;
        wr_tail    = 1'b0;
        wr_head    = 1'b0;

        result.result_kind       = KIND_SUBMITTED;
        result.slot_index        = ptr_out(tail);
        result.command_word_zero = 32'd0;
        result.command_tag       = last_tag;
        result.doorbell_write    = 1'b0;
        result.doorbell_offset   = 20'd0;
        result.doorbell_value    = 6'd0;
        result.status_code       = 15'd0;

        if (item.op == OP_SUBMIT) begin
            // tag zero is never handed out
            tag_next  = (tag_inc == 16'd0) ? 16'd1 : tag_inc;
            tail_next = (tail == PTR_LAST) ? '0 : tail + PTR_W'(1);
            wr_tail   = 1'b1;
            result.command_word_zero = {tag_next, item.command_low_word};
            result.command_tag       = tag_next;
            result.doorbell_write    = 1'b1;
            result.doorbell_offset   = bell_off;
            result.doorbell_value    = ptr_out(tail_next);
        end else begin
            result.slot_index = ptr_out(head);
            if (item.completion_status[0] != phase) begin
                result.result_kind = KIND_NOT_YET;
            end else if (item.completion_id != last_tag) begin
                result.result_kind = KIND_ID_MISMATCH;
            end else begin
                wr_head = 1'b1;
                if (head == PTR_LAST) begin
                    head_next  = '0;
                    phase_next = !phase;
                end else begin
                    head_next = head + PTR_W'(1);
                end
                result.result_kind     = (item.completion_status[15:1] == 15'd0) ?
                                         KIND_DONE_OK : KIND_DONE_ERROR;
                result.doorbell_write  = 1'b1;
                result.doorbell_offset = bell_off;
                result.doorbell_value  = ptr_out(head_next);
                result.status_code     = item.completion_status[15:1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_QUEUES; i++) begin
                tail_reg[i]  <= '0;
                head_reg[i]  <= '0;
                phase_reg[i] <= 1'b1;
                tag_reg[i]   <= 16'd0;
            end
        end else if (advance) begin
            if (wr_tail) begin
                tail_reg[q] <= tail_next;
                tag_reg[q]  <= tag_next;
            end
            if (wr_head) begin
                head_reg[q]  <= head_next;
                phase_reg[q] <= phase_next;
            end
        end
    end

endmodule

FILE: src/nvme_host_queue_pair_engine.sv
// top level: nvme host queue pair engine with input and result registers
// an accepted input transaction passes the input register, then the result register, to m_
// throughput: one transaction per cycle while m_tready is high, submit and completion alike
// the result register frees the input register whenever m_tready is high
// reset (aresetn low, synchronous): tails, heads and tags to zero, phases to one,
// stride exponent to zero, both registers empty
module nvme_host_queue_pair_engine
    import nhq_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [3:0]           cfg_wr_data,    // doorbell_stride_exp
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // command_low_word[15:0], completion_status[31:16], completion_id[47:32]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // op[0], queue_id[1]
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // slot_index[5:0], command_word_zero[37:6], command_tag[53:38],
    // doorbell_offset[73:54], doorbell_value[79:74], status_code[94:80], zero[95]
    output logic [M_TDATA_W-1:0] m_tdata,
    // result_kind[2:0], doorbell_write[3]
    output logic [M_TUSER_W-1:0] m_tuser
);

    logic [3:0] stride_exp_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    nhq_out_t   out_reg;

    logic     item_valid;
    nhq_in_t  item;
    nhq_out_t result;
    logic     advance;

    assign advance = item_valid && (!out_valid_reg || m_tready);

    nhq_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    nhq_engine u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .item       (item),
        .stride_exp (stride_exp_reg),
        .result     (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stride_exp_reg <= 4'd0;
        end else if (cfg_wr_en) begin
            stride_exp_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (advance) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0,
                       out_reg.status_code,
                       out_reg.doorbell_value,
                       out_reg.doorbell_offset,
                       out_reg.command_tag,
                       out_reg.command_word_zero,
                       out_reg.slot_index};
    assign m_tuser  = {out_reg.doorbell_write, out_reg.result_kind};

endmodule

FILE: dv/tb.sv
// testbench for the nvme host queue pair engine: directed and random transactions
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nhq_pkg::*;

    localparam int QUIET_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_ITEMS  = 2000;
    localparam int DRAIN_CYCLES  = 4;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [3:0]           cfg_wr_data = 4'd0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;
    logic [S_TUSER_W-1:0] s_tuser     = '0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    nvme_host_queue_pair_engine DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always #10 aclk = ~aclk;

    // queue pair bookkeeping as the host expects it; six-bit pointers wrap at depth 64
    logic [5:0]  tail_of  [NUM_QUEUES] = '{default: '0};
    logic [5:0]  head_of  [NUM_QUEUES] = '{default: '0};
    logic        phase_of [NUM_QUEUES] = '{default: 1'b1};
    logic [15:0] tag_of   [NUM_QUEUES] = '{default: '0};
    logic [3:0]  stride_exp = 4'd0;

    nhq_out_t pending_results[$];

    int error_count   = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int phase_flips   = 0;
    int tag_wraps     = 0;
    int kind_count [5] = '{default: 0};
    int quiet_cycles  = 0;
    int tx_idle_pct   = 0;
    int rx_stall_pct  = 0;
    int hold_seq      = 0;
    int hold_seen     = 0;
    int hold_left     = 0;

    task automatic report_error(input string msg);
        $display("mismatch: %s (result %0d)", msg, results_seen);
        error_count++;
    endtask

    function automatic logic [19:0] doorbell_addr(input logic q, input logic is_cpl);
        logic [31:0] sum;
        sum = 32'h1000 + 32'({q, is_cpl}) * (32'd4 << stride_exp);
        return sum[19:0];
    endfunction

    function automatic nhq_out_t predict_queue_pair(input nhq_in_t item);
        nhq_out_t    r;
        logic        q;
        logic [15:0] t;
        r = '0;
        q = item.queue_id;
        if (item.op == OP_SUBMIT) begin
            t = tag_of[q] + 16'd1;
            // tag zero is never handed out
            if (t == 16'd0) begin
                t = 16'd1;
                tag_wraps++;
            end
            tag_of[q] = t;
            r.result_kind       = KIND_SUBMITTED;
            r.slot_index        = tail_of[q];
            r.command_word_zero = {t, item.command_low_word};
            r.command_tag       = t;
            tail_of[q]          = tail_of[q] + 6'd1;
            r.doorbell_write    = 1'b1;
            r.doorbell_offset   = doorbell_addr(q, 1'b0);
            r.doorbell_value    = tail_of[q];
        end else begin
            r.slot_index  = head_of[q];
            r.command_tag = tag_of[q];
            if (item.completion_status[0] != phase_of[q]) begin
                r.result_kind = KIND_NOT_YET;
            end else if (item.completion_id != tag_of[q]) begin
                r.result_kind = KIND_ID_MISMATCH;
            end else begin
                head_of[q] = head_of[q] + 6'd1;
                if (head_of[q] == 6'd0) begin
                    phase_of[q] = ~phase_of[q];
                    phase_flips++;
                end
                r.doorbell_write  = 1'b1;
                r.doorbell_offset = doorbell_addr(q, 1'b1);
                r.doorbell_value  = head_of[q];
                r.status_code     = item.completion_status[15:1];
                r.result_kind     = (item.completion_status[15:1] == 15'd0) ?
                                    KIND_DONE_OK : KIND_DONE_ERROR;
            end
        end
        return r;
    endfunction

    function automatic nhq_in_t pack_item(input op_t op, input logic q,
                                          input logic [15:0] low, input logic [15:0] st,
                                          input logic [15:0] cid);
        nhq_in_t item;
        item.op                = op;
        item.queue_id          = q;
        item.command_low_word  = low;
        item.completion_status = st;
        item.completion_id     = cid;
        return item;
    endfunction

    task automatic send_item(input nhq_in_t item);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {item.completion_id, item.completion_status, item.command_low_word};
        s_tuser  <= {item.queue_id, item.op};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(predict_queue_pair(item));
        items_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_stride(input logic [3:0] value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        stride_exp  = value;
    endtask

    // mostly well-formed submit/complete traffic, the rest stale phase or wrong id
    task automatic send_random_traffic(input int count);
        int          roll;
        logic        q;
        logic [15:0] st;
        logic [15:0] cid;
        repeat (count) begin
            roll = $urandom_range(0, 99);
            q    = 1'($urandom_range(0, 1));
            st   = 16'($urandom);
            cid  = 16'($urandom);
            if (roll < 45) begin
                send_item(pack_item(OP_SUBMIT, q, 16'($urandom), st, cid));
            end else if (roll < 85) begin
                if ($urandom_range(0, 2) != 0) st[15:1] = 15'd0;
                st[0] = phase_of[q];
                send_item(pack_item(OP_COMPLETE, q, 16'($urandom), st, tag_of[q]));
            end else if (roll < 92) begin
                st[0] = ~phase_of[q];
                if ($urandom_range(0, 1) != 0) cid = tag_of[q];
                send_item(pack_item(OP_COMPLETE, q, 16'($urandom), st, cid));
            end else begin
                st[0] = phase_of[q];
                cid   = tag_of[q] ^ (16'd1 << $urandom_range(0, 15));
                send_item(pack_item(OP_COMPLETE, q, 16'($urandom), st, cid));
            end
        end
    endtask

    // completions before any submit await tag zero, then each queue submits and completes
    task automatic test_after_reset();
        send_item(pack_item(OP_COMPLETE, 1'b0, 16'h0000, 16'h0000, 16'h0000));
        send_item(pack_item(OP_COMPLETE, 1'b1, 16'h0000, 16'h0001, 16'h0001));
        send_item(pack_item(OP_COMPLETE, 1'b0, 16'hffff, 16'h0001, 16'h0000));
        send_item(pack_item(OP_COMPLETE, 1'b1, 16'h0000, 16'hffff, 16'h0000));
        send_item(pack_item(OP_SUBMIT,   1'b0, 16'hffff, 16'h0000, 16'h0000));
        send_item(pack_item(OP_SUBMIT,   1'b1, 16'h0000, 16'hffff, 16'hffff));
        send_item(pack_item(OP_COMPLETE, 1'b0, 16'h0000, 16'h0001, tag_of[0]));
        send_item(pack_item(OP_COMPLETE, 1'b1, 16'h0000, 16'hffff, 16'hffff));
        send_item(pack_item(OP_COMPLETE, 1'b1, 16'h0000, 16'hfffe, tag_of[1]));
        send_item(pack_item(OP_COMPLETE, 1'b1, 16'h0000, 16'hffff, tag_of[1]));
    endtask

    task automatic test_stride_extremes();
        write_stride(4'd15);
        send_item(pack_item(OP_SUBMIT,   1'b1, 16'h1234, 16'h0000, 16'h0000));
        send_item(pack_item(OP_COMPLETE, 1'b1, 16'h0000, {15'd0, phase_of[1]}, tag_of[1]));
        send_item(pack_item(OP_SUBMIT,   1'b0, 16'habcd, 16'h0000, 16'h0000));
        send_item(pack_item(OP_COMPLETE, 1'b0, 16'h0000, {15'h7fff, phase_of[0]},
                            tag_of[0]));
        write_stride(4'd0);
        send_item(pack_item(OP_SUBMIT,   1'b1, 16'h8001, 16'h0000, 16'h0000));
        send_item(pack_item(OP_COMPLETE, 1'b1, 16'h0000, {15'd0, phase_of[1]}, tag_of[1]));
    endtask

    // run the admin queue around the ring so tail, head and phase all wrap
    task automatic test_pointer_wrap();
        repeat (70) begin
            send_item(pack_item(OP_SUBMIT, 1'b0, 16'($urandom), 16'($urandom),
                                16'($urandom)));
            send_item(pack_item(OP_COMPLETE, 1'b0, 16'h0000, {15'd0, phase_of[0]},
                                tag_of[0]));
        end
        drain_results();
    endtask

    // receiver holds off long enough to back the block up, then the sender waits it out
    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_stall_pct <= 0;
        hold_seq <= hold_seq + 1;
        send_random_traffic(24);
        drain_results();
    endtask

    task automatic test_random_traffic();
        logic [3:0] stride;
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: stride = 4'd0;
                1: stride = 4'd15;
                default: stride = 4'($urandom_range(1, 14));
            endcase
            write_stride(stride);
            case (p)
                0: begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
                1: begin tx_idle_pct = 54; rx_stall_pct <= 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct <= 54; end
                default: begin tx_idle_pct = 31; rx_stall_pct <= 31; end
            endcase
            send_random_traffic(RANDOM_ITEMS / 4);
        end
        tx_idle_pct = 0;
        rx_stall_pct <= 0;
    endtask

    always @(posedge aclk) begin
        if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    always @(posedge aclk) begin
        nhq_out_t got;
        nhq_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.result_kind       = kind_t'(m_tuser[2:0]);
            got.doorbell_write    = m_tuser[3];
            got.slot_index        = m_tdata[5:0];
            got.command_word_zero = m_tdata[37:6];
            got.command_tag       = m_tdata[53:38];
            got.doorbell_offset   = m_tdata[73:54];
            got.doorbell_value    = m_tdata[79:74];
            got.status_code       = m_tdata[94:80];
            if (pending_results.size() == 0) begin
                report_error("result transaction with nothing pending");
            end else begin
                want = pending_results.pop_front();
                kind_count[want.result_kind]++;
                if (got.result_kind !== want.result_kind)
                    report_error($sformatf("result_kind got %0d expected %0d",
                                           got.result_kind, want.result_kind));
                if (got.slot_index !== want.slot_index)
                    report_error($sformatf("slot_index got %0d expected %0d",
                                           got.slot_index, want.slot_index));
                if (got.command_word_zero !== want.command_word_zero)
                    report_error($sformatf("command_word_zero got %h expected %h",
                                           got.command_word_zero, want.command_word_zero));
                if (got.command_tag !== want.command_tag)
                    report_error($sformatf("command_tag got %h expected %h",
                                           got.command_tag, want.command_tag));
                if (got.doorbell_write !== want.doorbell_write)
                    report_error($sformatf("doorbell_write got %b expected %b",
                                           got.doorbell_write, want.doorbell_write));
                if (got.doorbell_offset !== want.doorbell_offset)
                    report_error($sformatf("doorbell_offset got %h expected %h",
                                           got.doorbell_offset, want.doorbell_offset));
                if (got.doorbell_value !== want.doorbell_value)
                    report_error($sformatf("doorbell_value got %0d expected %0d",
                                           got.doorbell_value, want.doorbell_value));
                if (got.status_code !== want.status_code)
                    report_error($sformatf("status_code got %h expected %h",
                                           got.status_code, want.status_code));
                if (m_tdata[95] !== 1'b0)
                    report_error("tdata pad bit not zero");
            end
            results_seen++;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge aclk);
        $display("[nvme_host_queue_pair_engine] ERROR");
        $finish;
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        test_after_reset();
        test_stride_extremes();
        test_pointer_wrap();
        test_backpressure();
        test_random_traffic();
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0)
            report_error($sformatf("%0d results never arrived", pending_results.size()));
        $display("covered %0d transactions in, %0d out, %0d phase flips, %0d tag wraps",
                 items_sent, results_seen, phase_flips, tag_wraps);
        $display("kinds: submitted %0d, not yet %0d, id mismatch %0d, ok %0d, error %0d",
                 kind_count[0], kind_count[1], kind_count[2], kind_count[3], kind_count[4]);
        if (error_count == 0) begin
            $display("[nvme_host_queue_pair_engine] OK");
        end else begin
            $display("[nvme_host_queue_pair_engine] ERROR");
        end
        $finish;
    end

endmodule
